### rtl/core/tp2u_pkg.sv
// Shared types, constants and the Telex pair lookup for telex_pair_to_utf8.
// Used by tp2u_front, tp2u_queue and tp2u_back; no dependencies of its own.

package tp2u_pkg;

  // UTF-8 byte pairs, lower case then upper case
  localparam logic [15:0] DD_LO = 16'hC491;
  localparam logic [15:0] DD_UP = 16'hC490;
  localparam logic [15:0] OO_LO = 16'hC3B4;
  localparam logic [15:0] OO_UP = 16'hC394;
  localparam logic [15:0] AA_LO = 16'hC3A2;
  localparam logic [15:0] AA_UP = 16'hC382;
  localparam logic [15:0] EE_LO = 16'hC3AA;
  localparam logic [15:0] EE_UP = 16'hC38A;
  localparam logic [15:0] UW_LO = 16'hC6B0;
  localparam logic [15:0] UW_UP = 16'hC6AF;
  localparam logic [15:0] AW_LO = 16'hC483;
  localparam logic [15:0] AW_UP = 16'hC482;
  localparam logic [15:0] OW_LO = 16'hC6A1;
  localparam logic [15:0] OW_UP = 16'hC6A0;

  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // One queued request: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] utf8;
  } pair_map_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } back_phase_e;

  function automatic logic is_upper(input logic [7:0] c);
    is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    fold_lower = is_upper(c) ? 8'(c + CASE_OFFSET) : c;
  endfunction

  // Match a held byte against the next byte, case-insensitive
  function automatic pair_map_t pair_map(input logic [7:0] a, input logic [7:0] b);
    pair_map_t   res;
    logic        up;
    logic [15:0] key;
    up  = is_upper(a);
    key = {fold_lower(a), fold_lower(b)};
    res.hit = 1'b1;
    unique case (key)
      16'h6464: res.utf8 = up ? DD_UP : DD_LO;   // dd
      16'h6F6F: res.utf8 = up ? OO_UP : OO_LO;   // oo
      16'h6161: res.utf8 = up ? AA_UP : AA_LO;   // aa
      16'h6565: res.utf8 = up ? EE_UP : EE_LO;   // ee
      16'h7777: res.utf8 = up ? UW_UP : UW_LO;   // ww
      16'h6177: res.utf8 = up ? AW_UP : AW_LO;   // aw
      16'h6F77: res.utf8 = up ? OW_UP : OW_LO;   // ow
      16'h7577: res.utf8 = up ? UW_UP : UW_LO;   // uw
      default: begin
        res.hit  = 1'b0;
        res.utf8 = '0;
      end
    endcase
    pair_map = res;
  endfunction

endpackage

### rtl/core/tp2u_front.sv
// Front end: accepts input bytes, keeps the pending byte and classifies pairs.
// Depends on tp2u_pkg; pushes requests into tp2u_queue.

module tp2u_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output tp2u_pkg::cmd_t cmd_o
);

  logic                 held_valid_q, held_valid_d;
  logic [7:0]           held_byte_q, held_byte_d;
  logic                 accept;
  logic                 has_out;
  tp2u_pkg::pair_map_t  map;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign map        = tp2u_pkg::pair_map(held_byte_q, in_byte_i);
  assign push_o     = accept && has_out;

  always_comb begin
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    has_out      = 1'b0;
    cmd_o        = '0;
    if (!held_valid_q) begin
      if (in_last_i) begin
        has_out     = 1'b1;
        cmd_o.byte0 = in_byte_i;
        cmd_o.last0 = 1'b1;
      end else begin
        held_valid_d = 1'b1;
        held_byte_d  = in_byte_i;
      end
    end else if (map.hit) begin
      has_out      = 1'b1;
      cmd_o.two    = 1'b1;
      cmd_o.byte0  = map.utf8[15:8];
      cmd_o.byte1  = map.utf8[7:0];
      cmd_o.last1  = in_last_i;
      held_valid_d = 1'b0;
      held_byte_d  = '0;
    end else begin
      // pass the held byte on; flush the new one too at end of string
      has_out     = 1'b1;
      cmd_o.byte0 = held_byte_q;
      if (in_last_i) begin
        cmd_o.two    = 1'b1;
        cmd_o.byte1  = in_byte_i;
        cmd_o.last1  = 1'b1;
        held_valid_d = 1'b0;
        held_byte_d  = '0;
      end else begin
        held_byte_d = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
    end else if (accept) begin
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
    end
  end

endmodule

### rtl/core/tp2u_queue.sv
// Short request queue between front and back end.
// Depends on tp2u_pkg for the request type.

module tp2u_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tp2u_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output tp2u_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tp2u_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
`endif

endmodule

### rtl/core/tp2u_back.sv
// Back end: pops requests and sends one or two bytes through the output register.
// Depends on tp2u_pkg for the request type and the phase enum.

module tp2u_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tp2u_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  input  logic           out_ready_i
);

  tp2u_pkg::back_phase_e phase_q, phase_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  out_last_q, out_last_d;
  logic                  can_load;

  assign can_load = !out_valid_q || out_ready_i;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (can_load) begin
      unique case (phase_q)
        tp2u_pkg::PH_FIRST: begin
          if (!empty_i && head_i.two) begin
            phase_d = tp2u_pkg::PH_SECOND;
          end
        end
        tp2u_pkg::PH_SECOND: phase_d = tp2u_pkg::PH_FIRST;
        default:             phase_d = tp2u_pkg::PH_FIRST;
      endcase
    end
  end

  // output register load and pop
  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (can_load) begin
      unique case (phase_q)
        tp2u_pkg::PH_FIRST: begin
          if (!empty_i) begin
            out_valid_d = 1'b1;
            out_byte_d  = head_i.byte0;
            out_last_d  = head_i.last0;
            pop_o       = !head_i.two;
          end
        end
        tp2u_pkg::PH_SECOND: begin
          out_valid_d = 1'b1;
          out_byte_d  = head_i.byte1;
          out_last_d  = head_i.last1;
          pop_o       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tp2u_pkg::PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tp2u_pkg::PH_SECOND) |-> !empty_i)
    else $error("second byte phase without a queued request");
  a_second_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tp2u_pkg::PH_SECOND) |-> head_i.two)
    else $error("second byte phase on a one-byte request");
`endif

endmodule

### rtl/core/telex_pair_to_utf8_core.sv
// Top level of the Telex pair to UTF-8 converter.
// Instantiates tp2u_front, tp2u_queue and tp2u_back; uses tp2u_pkg.
//
// Usage:
//   Slave stream s_axis carries one ASCII byte per beat (tdata) with tlast
//   on the final byte of a string. Master stream m_axis carries the output
//   bytes, plain ASCII or UTF-8 sequences, with tlast on the final byte.
//   Each input byte yields zero, one or two output bytes; a byte is held
//   until the next one shows whether the two form a Telex pair.
//   Path: an output byte reaches m_axis through the request queue, then the
//   output register, after the input byte that releases it is accepted.
//   Throughput: one input byte per cycle is accepted while the queue has
//   room; the output register sends one byte per cycle while m_axis_tready
//   is high, so a byte that produces two outputs holds the output side for
//   both of them. The queue depth (QueueDepth) sets how long the input side
//   runs on while the output side works off two-byte requests.
//   Reset: clears the pending byte, empties the queue, drops m_axis_tvalid.
//   Stall: when m_axis_tready is low the output register holds its byte,
//   the queue fills and s_axis_tready falls once it is full.

module telex_pair_to_utf8_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  tp2u_pkg::cmd_t push_cmd;
  tp2u_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  tp2u_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tp2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  tp2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

`ifndef NO_ASSERTIONS
  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !q_full) else $error("input ready does not follow queue room");
`endif

endmodule
